@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ahsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ahsc_pkg
// Shared types, constants and elaboration-time helpers of the audio clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package ahsc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PARAM_W   = 32;
  localparam int CFG_IDX_W = 2;
  // tanh table values are Q2.30 below 1.0, so 30 bits hold them
  localparam int TQ_W      = 30;

  localparam logic [PARAM_W-1:0] PARAM_A_RST = 32'hFFFF_0000;
  localparam logic [PARAM_W-1:0] PARAM_B_RST = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_MODE = 2'd0,
    CFG_PARAM_A   = 2'd1,
    CFG_PARAM_B   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    MODE_CLAMP = 1'b0,
    MODE_TANH  = 1'b1
  } clip_mode_t;

  // saturate a sign and magnitude to a 16 bit two's complement sample
  function automatic logic [SAMPLE_W-1:0] sat16(input logic neg, input logic [31:0] mag);
    logic [SAMPLE_W-1:0] res;
    if (neg) begin
      if (mag >= 32'd32768) res = 16'h8000;
      else res = 16'(32'd65536 - mag);
    end else begin
      if (mag > 32'd32767) res = 16'h7FFF;
      else res = mag[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // shift-subtract division, only used on constants at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(8k/2^tbits) in Q2.30: exp(-2u) from a short series squared eight times
  function automatic logic [TQ_W-1:0] tanh_entry(input int unsigned k, input int unsigned tbits);
    logic [63:0] one;
    logic [63:0] h;
    logic [63:0] term;
    logic signed [63:0] e;
    logic [63:0] eu;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    one  = 64'd1 << 30;
    h    = 64'(k) << (26 - tbits);
    term = one;
    e    = signed'(one);
    term = (term * h) >> 30;
    e    = e - signed'(term);
    term = ((term * h) >> 30) / 2;
    e    = e + signed'(term);
    term = ((term * h) >> 30) / 3;
    e    = e - signed'(term);
    term = ((term * h) >> 30) / 4;
    e    = e + signed'(term);
    term = ((term * h) >> 30) / 5;
    e    = e - signed'(term);
    term = ((term * h) >> 30) / 6;
    e    = e + signed'(term);
    if (e < 0) eu = '0;
    else if (unsigned'(e) > one) eu = one;
    else eu = unsigned'(e);
    for (int n = 0; n < 8; n++) begin
      eu = (eu * eu + (64'd1 << 29)) >> 30;
    end
    num = ((one - eu) << 30) + ((one + eu) >> 1);
    den = one + eu;
    q   = udiv64(num, den);
    return q[TQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/ahsc_tanh_rom.sv @@
// ----------------------------------------------------------------------------
// ahsc_tanh_rom
// Constant tanh table, one word per segment holding slope and base value,
// read through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ahsc_tanh_rom #(
  parameter int TBITS = 8
) (
  input  wire logic                           clk,
  input  wire logic [TBITS-1:0]               rd_addr,
  output logic      [2*ahsc_pkg::TQ_W-1:0]    rd_data
);
  import ahsc_pkg::*;

  localparam int DEPTH = 1 << TBITS;
  localparam int ROM_W = 2 * TQ_W;

  typedef logic [ROM_W-1:0] rom_arr_t [DEPTH];

  // word k = {tbl[k+1] - tbl[k], tbl[k]}, the table rises monotonically
  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    logic [TQ_W-1:0] lo;
    logic [TQ_W-1:0] hi;
    for (int k = 0; k < DEPTH; k++) begin
      lo = tanh_entry(k, TBITS);
      hi = tanh_entry(k + 1, TBITS);
      r[k] = {hi - lo, lo};
    end
    return r;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  logic [ROM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= ROM[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/audio_hard_soft_clipper_top.sv @@
// ----------------------------------------------------------------------------
// audio_hard_soft_clipper_top
// Hard clamp or scaled tanh soft clip of signed Q1.15 audio samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a sample is taken at a rising edge with start high and busy low.
//   busy stays low, so a new sample may be offered in every cycle.
//   Output: each result shows on out_sample for one cycle with out_strobe
//   high; the receiver has to take it in that cycle.
//   Throughput is one sample per clock. A result passes through six register
//   stages, the first loaded at the accepting edge: gain multiply, magnitude
//   and table read, slope multiply, interpolation add, output gain multiply,
//   rounding and saturation; out_strobe rises as the last stage is loaded.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 clip
//   mode, 1 param_a, 2 param_b) at the edge; other indexes are ignored.
//   Write it only while no sample is in flight.
//   Reset (rst_n low at an edge) drops every sample in flight and restores
//   clamp mode with bounds -1.0 and +1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_hard_soft_clipper_top #(
  parameter int TANH_TABLE_BITS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [ahsc_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                       out_strobe,
  output logic signed      [ahsc_pkg::SAMPLE_W-1:0]  out_sample,
  input  wire logic                                  cfg_we,
  input  wire logic        [ahsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [ahsc_pkg::PARAM_W-1:0]   cfg_wdata
);
  import ahsc_pkg::*;

  localparam int TB   = TANH_TABLE_BITS;
  localparam int FB   = 34 - TB;
  localparam int PW   = TQ_W + FB;
  localparam int P_W  = PARAM_W + SAMPLE_W;
  localparam logic [TQ_W-1:0] TANH_LAST = tanh_entry(1 << TB, TB);
  localparam logic [PW:0]     HALF_F    = (PW + 1)'(1) << (FB - 1);

  // configuration registers
  logic                       mode_r;
  logic signed [PARAM_W-1:0]  param_a_r;
  logic signed [PARAM_W-1:0]  param_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_CLAMP;
      param_a_r <= PARAM_A_RST;
      param_b_r <= PARAM_B_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_MODE: mode_r    <= cfg_wdata[0];
        CFG_PARAM_A:   param_a_r <= cfg_wdata;
        CFG_PARAM_B:   param_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: input gain product and clamp select
  logic                      v1_r, mode1_r;
  logic signed [P_W-1:0]     p1_r;
  logic signed [PARAM_W-1:0] d1_r;
  logic signed [P_W-1:0]     p1_nxt;
  logic signed [PARAM_W-1:0] dbl;
  logic signed [PARAM_W-1:0] d1_nxt;

  assign p1_nxt = P_W'(param_b_r) * P_W'(in_sample);
  assign dbl    = {{(PARAM_W - SAMPLE_W - 1){in_sample[SAMPLE_W-1]}}, in_sample, 1'b0};

  always_comb begin
    // lower bound checked first, so it wins for samples below it when the bounds cross
    if (dbl < param_a_r) d1_nxt = param_a_r;
    else if (dbl > param_b_r) d1_nxt = param_b_r;
    else d1_nxt = dbl;
  end

  // stage 2: magnitude, table read, clamp rounding
  logic                 v2_r, mode2_r, sat2_r, negp2_r;
  logic [FB-1:0]        frac2_r;
  logic [SAMPLE_W-1:0]  clamp2_r;
  logic [P_W-1:0]       m1;
  logic [PARAM_W:0]     dsx, dm, dr;
  logic [2*TQ_W-1:0]    rom_rd;

  assign m1  = p1_r[P_W-1] ? (P_W'(0) - p1_r) : p1_r;
  assign dsx = {d1_r[PARAM_W-1], d1_r};
  assign dm  = d1_r[PARAM_W-1] ? ((PARAM_W + 1)'(0) - dsx) : dsx;
  assign dr  = dm + (PARAM_W + 1)'(1);

  ahsc_tanh_rom #(.TBITS(TB)) u_rom (
    .clk     (clk),
    .rd_addr (m1[33:FB]),
    .rd_data (rom_rd)
  );

  // stage 3: slope times fraction
  logic                 v3_r, mode3_r, sat3_r, negp3_r;
  logic [SAMPLE_W-1:0]  clamp3_r;
  logic [TQ_W-1:0]      base3_r;
  logic [PW-1:0]        prod3_r;
  logic [PW-1:0]        prod3_nxt;

  assign prod3_nxt = PW'(rom_rd[2*TQ_W-1:TQ_W]) * PW'(frac2_r);

  // stage 4: interpolated tanh magnitude
  logic                 v4_r, mode4_r, negp4_r;
  logic [SAMPLE_W-1:0]  clamp4_r;
  logic [TQ_W-1:0]      t4_r;
  logic [PW:0]          rnd3;
  logic [TQ_W-1:0]      t4_nxt;

  assign rnd3   = {1'b0, prod3_r} + HALF_F;
  assign t4_nxt = sat3_r ? TANH_LAST : (base3_r + rnd3[FB +: TQ_W]);

  // stage 5: output gain product
  logic                       v5_r, mode5_r, negp5_r;
  logic [SAMPLE_W-1:0]        clamp5_r;
  logic [PARAM_W+TQ_W-1:0]    prod5_r;
  logic [PARAM_W-1:0]         amag;

  assign amag = param_a_r[PARAM_W-1] ? (PARAM_W'(0) - param_a_r) : param_a_r;

  // stage 6: rounding, sign and saturation
  logic                       out_strobe_r;
  logic [SAMPLE_W-1:0]        out_sample_r;
  logic [PARAM_W+TQ_W-1:0]    tr;
  logic [TQ_W:0]              tmag;
  logic                       tneg;
  logic [SAMPLE_W-1:0]        out_nxt;

  assign tr   = prod5_r + (PARAM_W + TQ_W)'(64'h4000_0000);
  assign tmag = tr[PARAM_W+TQ_W-1:31];
  assign tneg = (tmag != '0) && (negp5_r != param_a_r[PARAM_W-1]);
  assign out_nxt = mode5_r ? sat16(tneg, 32'(tmag)) : clamp5_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= accept;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      v5_r         <= v4_r;
      out_strobe_r <= v5_r;
    end
  end

  // data path, free running since the receiver never stalls
  always_ff @(posedge clk) begin
    mode1_r      <= mode_r;
    p1_r         <= p1_nxt;
    d1_r         <= d1_nxt;

    mode2_r      <= mode1_r;
    sat2_r       <= |m1[P_W-1:34];
    negp2_r      <= p1_r[P_W-1];
    frac2_r      <= m1[FB-1:0];
    clamp2_r     <= sat16(d1_r[PARAM_W-1], dr[PARAM_W:1]);

    mode3_r      <= mode2_r;
    sat3_r       <= sat2_r;
    negp3_r      <= negp2_r;
    clamp3_r     <= clamp2_r;
    base3_r      <= rom_rd[TQ_W-1:0];
    prod3_r      <= prod3_nxt;

    mode4_r      <= mode3_r;
    negp4_r      <= negp3_r;
    clamp4_r     <= clamp3_r;
    t4_r         <= t4_nxt;

    mode5_r      <= mode4_r;
    negp5_r      <= negp4_r;
    clamp5_r     <= clamp4_r;
    prod5_r      <= (PARAM_W + TQ_W)'(amag) * (PARAM_W + TQ_W)'(t4_r);

    out_sample_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_sample = out_sample_r;

endmodule

`default_nettype wire

@@ sv/ahsc_checker.sv @@
// ----------------------------------------------------------------------------
// ahsc_checker
// Port level checks of the audio clipper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ahsc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_strobe,
  input wire logic [15:0] out_sample
);

  logic acc;
  assign acc = start && !busy;

  // the block never holds the sender off
  `ASSERT_CLK(a_never_busy, clk, rst_n, busy == 1'b0, "busy raised")

  // every accepted transaction is followed by its strobed result
  `ASSERT_CLK(a_result_follows, clk, rst_n, acc |-> ##6 out_strobe, "result lost")

  // no result without an earlier accepted transaction
  `ASSERT_CLK(a_no_spurious, clk, rst_n, out_strobe |-> $past(acc && rst_n, 6), "spurious result")

  // a strobed result carries a known sample
  `ASSERT_CLK(a_sample_known, clk, rst_n, out_strobe |-> !$isunknown(out_sample), "unknown result")

  // reset empties the pipeline, strobe known and low
  `ASSERT_CLK_ALWAYS(a_reset_flush, clk, !rst_n |=> !out_strobe && !$isunknown(out_strobe), "strobe after reset")

endmodule

bind audio_hard_soft_clipper_top ahsc_checker u_ahsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_sample (out_sample)
);

`default_nettype wire
